[src/sawarq_pkg.sv]
// ----------------------------------------------------------------------------
// sawarq_pkg: shared codes for the stop-and-wait ARQ block
// Request operation codes, result kind codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sawarq_pkg;

  localparam int OP_W   = 3;
  localparam int KIND_W = 3;
  localparam int ATT_W  = 8;
  localparam int CFG_W  = 16;

  localparam logic [OP_W-1:0] OP_SUBMIT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA_IN  = 3'd1;
  localparam logic [OP_W-1:0] OP_ACK_IN   = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
  localparam logic [OP_W-1:0] OP_DATA_WAKE = 3'd4;
  localparam logic [OP_W-1:0] OP_ACK_WAKE = 3'd5;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd6;

  localparam logic [KIND_W-1:0] KIND_DATA   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS = 3'd5;

  localparam logic [ATT_W-1:0] ATT_MAX   = 8'd255;
  localparam logic [CFG_W-1:0] RESEND_RST = 16'd1000;

endpackage

`default_nettype wire

[src/stop_and_wait_arq.sv]
// ----------------------------------------------------------------------------
// stop_and_wait_arq: sender and receiver ends of a stop-and-wait ARQ link
// One request per cycle updates the link state; results go to a small queue, and requests wait while it is nearly full.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per beat. in_tuser carries the operation; in_tdata
//           carries seq_in, frame_handle, data_path_free, ack_path_free.
//   out_* : zero, one or two results per request. out_tuser is the kind,
//           out_tlast marks the final result of a request.
//   cfg_* : write resend_ticks (ticks before a resend) at any idle time.
// Output: each result is registered into the queue when its request is taken.
// Throughput: one request per cycle while each makes at most one result and
//   out_tready stays high; a two-result request writes both to the queue.
//   The state update is a single pass of compares and counters; the output
//   queue (4 entries) sets how far requests may run ahead of a stalled receiver.
// Reset: sequence numbers, timer, flags and queue clear; resend_ticks = 1000.
// Receiver stall: results wait in the queue; in_tready drops when fewer
//   than two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_arq #(
  parameter int SEQ_BITS    = 8,
  parameter int HANDLE_BITS = 16,
  parameter int TIMER_BITS  = 16,
  localparam int IN_DATA_W  = ((SEQ_BITS + HANDLE_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_DATA_W =
    ((SEQ_BITS + HANDLE_BITS + sawarq_pkg::ATT_W + 1 + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [sawarq_pkg::CFG_W-1:0]  cfg_wr_data,
  // requests
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // tdata, low to high: seq_in, frame_handle, data_path_free, ack_path_free
  input  wire logic [IN_DATA_W-1:0]          in_tdata,
  // tuser: operation
  input  wire logic [sawarq_pkg::OP_W-1:0]   in_tuser,
  // results
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // tdata, low to high: seq_out, handle_out, attempt, accepting
  output logic [OUT_DATA_W-1:0]              out_tdata,
  // tuser: kind
  output logic [sawarq_pkg::KIND_W-1:0]      out_tuser,
  output logic                               out_tlast
);

  localparam int ENT_W      = sawarq_pkg::KIND_W + OUT_DATA_W + 1;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef logic [SEQ_BITS-1:0]    seq_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [TIMER_BITS-1:0]  timer_t;
  typedef logic [ENT_W-1:0]       entry_t;

  // link state
  logic [sawarq_pkg::CFG_W-1:0] resend_r;
  seq_t    next_send_r, next_send_nxt;
  seq_t    exp_recv_r, exp_recv_nxt;
  logic    outstanding_r, outstanding_nxt;
  handle_t held_handle_r, held_handle_nxt;
  seq_t    held_seq_r, held_seq_nxt;
  logic [sawarq_pkg::ATT_W-1:0] attempt_r, attempt_nxt;
  logic    send_def_r, send_def_nxt;
  logic    ack_def_r, ack_def_nxt;
  seq_t    def_ack_seq_r, def_ack_seq_nxt;
  timer_t  timer_r, timer_nxt;
  logic    timer_run_r, timer_run_nxt;

  // request fields
  seq_t    rq_seq;
  handle_t rq_handle;
  logic    rq_dfree, rq_afree;
  logic    in_fire;
  timer_t  timer_load;
  seq_t    exp_prev, send_prev;
  logic    fresh;

  // results of the current request
  logic [1:0] n_res;
  logic [sawarq_pkg::KIND_W-1:0] r_kind [2];
  seq_t    r_seq [2];
  handle_t r_handle [2];
  logic [sawarq_pkg::ATT_W-1:0] r_att [2];
  logic    accepting;
  entry_t  r_ent [2];

  // result queue
  entry_t q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              pop;

  assign rq_seq    = in_tdata[SEQ_BITS-1:0];
  assign rq_handle = in_tdata[SEQ_BITS +: HANDLE_BITS];
  assign rq_dfree  = in_tdata[SEQ_BITS + HANDLE_BITS];
  assign rq_afree  = in_tdata[SEQ_BITS + HANDLE_BITS + 1];
  assign in_fire   = in_tvalid && in_tready;

  generate
    if (TIMER_BITS >= sawarq_pkg::CFG_W) begin : g_tload_wide
      assign timer_load = timer_t'(resend_r);
    end else begin : g_tload_narrow
      assign timer_load = resend_r[TIMER_BITS-1:0];
    end
  endgenerate

  assign exp_prev  = exp_recv_r - seq_t'(1);
  assign send_prev = next_send_r - seq_t'(1);
  assign fresh     = (rq_seq == exp_recv_r);

  always_comb begin
    next_send_nxt   = next_send_r;
    exp_recv_nxt    = exp_recv_r;
    outstanding_nxt = outstanding_r;
    held_handle_nxt = held_handle_r;
    held_seq_nxt    = held_seq_r;
    attempt_nxt     = attempt_r;
    send_def_nxt    = send_def_r;
    ack_def_nxt     = ack_def_r;
    def_ack_seq_nxt = def_ack_seq_r;
    timer_nxt       = timer_r;
    timer_run_nxt   = timer_run_r;
    n_res           = 2'd0;
    for (int i = 0; i < 2; i++) begin
      r_kind[i]   = sawarq_pkg::KIND_ERROR;
      r_seq[i]    = '0;
      r_handle[i] = '0;
      r_att[i]    = '0;
    end

    unique case (in_tuser)
      sawarq_pkg::OP_SUBMIT: begin
        if (outstanding_r) begin
          n_res = 2'd1;
        end else begin
          outstanding_nxt = 1'b1;
          held_handle_nxt = rq_handle;
          held_seq_nxt    = next_send_r;
          attempt_nxt     = sawarq_pkg::ATT_W'(1);
          next_send_nxt   = next_send_r + seq_t'(1);
          if (rq_dfree) begin
            timer_nxt     = timer_load;
            timer_run_nxt = 1'b1;
            send_def_nxt  = 1'b0;
            n_res         = 2'd1;
            r_kind[0]     = sawarq_pkg::KIND_DATA;
            r_seq[0]      = next_send_r;
            r_handle[0]   = rq_handle;
            r_att[0]      = sawarq_pkg::ATT_W'(1);
          end else begin
            send_def_nxt = 1'b1;
          end
        end
      end
      sawarq_pkg::OP_DATA_IN: begin
        if (!fresh && rq_seq != exp_prev) begin
          n_res = 2'd1;
        end else begin
          // ack always carries the number expected after this frame
          if (fresh) exp_recv_nxt = exp_recv_r + seq_t'(1);
          if (rq_afree) begin
            ack_def_nxt = 1'b0;
            n_res       = 2'd1;
            r_kind[0]   = sawarq_pkg::KIND_ACK;
            r_seq[0]    = exp_recv_nxt;
            if (fresh) begin
              n_res       = 2'd2;
              r_kind[1]   = sawarq_pkg::KIND_UP;
              r_seq[1]    = rq_seq;
              r_handle[1] = rq_handle;
            end
          end else begin
            ack_def_nxt     = 1'b1;
            def_ack_seq_nxt = exp_recv_nxt;
            if (fresh) begin
              n_res       = 2'd1;
              r_kind[0]   = sawarq_pkg::KIND_UP;
              r_seq[0]    = rq_seq;
              r_handle[0] = rq_handle;
            end
          end
        end
      end
      sawarq_pkg::OP_ACK_IN: begin
        if (rq_seq != next_send_r && rq_seq != send_prev) begin
          n_res = 2'd1;
        end else if (rq_seq == next_send_r && outstanding_r) begin
          outstanding_nxt = 1'b0;
          send_def_nxt    = 1'b0;
          timer_run_nxt   = 1'b0;
          timer_nxt       = '0;
          n_res           = 2'd1;
          r_kind[0]       = sawarq_pkg::KIND_READY;
        end
      end
      sawarq_pkg::OP_TICK: begin
        if (timer_run_r) begin
          if (timer_r > timer_t'(1)) begin
            timer_nxt = timer_r - timer_t'(1);
          end else begin
            timer_nxt     = '0;
            timer_run_nxt = 1'b0;
            if (outstanding_r) begin
              if (attempt_r != sawarq_pkg::ATT_MAX) begin
                attempt_nxt = attempt_r + sawarq_pkg::ATT_W'(1);
              end
              if (rq_dfree) begin
                timer_nxt     = timer_load;
                timer_run_nxt = 1'b1;
                send_def_nxt  = 1'b0;
                n_res         = 2'd1;
                r_kind[0]     = sawarq_pkg::KIND_DATA;
                r_seq[0]      = held_seq_r;
                r_handle[0]   = held_handle_r;
                r_att[0]      = attempt_nxt;
              end else begin
                send_def_nxt = 1'b1;
              end
            end
          end
        end
      end
      sawarq_pkg::OP_DATA_WAKE: begin
        if (send_def_r && outstanding_r && rq_dfree) begin
          timer_nxt     = timer_load;
          timer_run_nxt = 1'b1;
          send_def_nxt  = 1'b0;
          n_res         = 2'd1;
          r_kind[0]     = sawarq_pkg::KIND_DATA;
          r_seq[0]      = held_seq_r;
          r_handle[0]   = held_handle_r;
          r_att[0]      = attempt_r;
        end else if (!outstanding_r && rq_dfree) begin
          n_res     = 2'd1;
          r_kind[0] = sawarq_pkg::KIND_READY;
        end
      end
      sawarq_pkg::OP_ACK_WAKE: begin
        if (ack_def_r && rq_afree) begin
          ack_def_nxt = 1'b0;
          n_res       = 2'd1;
          r_kind[0]   = sawarq_pkg::KIND_ACK;
          r_seq[0]    = def_ack_seq_r;
        end
      end
      sawarq_pkg::OP_QUERY: begin
        n_res     = 2'd1;
        r_kind[0] = sawarq_pkg::KIND_STATUS;
        r_att[0]  = attempt_r;
      end
      default: ;
    endcase

    accepting = !outstanding_nxt && rq_dfree;
    for (int i = 0; i < 2; i++) begin
      r_ent[i] = {r_kind[i],
                  OUT_DATA_W'({accepting, r_att[i], r_handle[i], r_seq[i]}),
                  (i == 0) ? (n_res == 2'd1) : 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resend_r      <= sawarq_pkg::RESEND_RST;
      next_send_r   <= '0;
      exp_recv_r    <= '0;
      outstanding_r <= 1'b0;
      attempt_r     <= '0;
      send_def_r    <= 1'b0;
      ack_def_r     <= 1'b0;
      timer_r       <= '0;
      timer_run_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) resend_r <= cfg_wr_data;
      if (in_fire) begin
        next_send_r   <= next_send_nxt;
        exp_recv_r    <= exp_recv_nxt;
        outstanding_r <= outstanding_nxt;
        attempt_r     <= attempt_nxt;
        send_def_r    <= send_def_nxt;
        ack_def_r     <= ack_def_nxt;
        timer_r       <= timer_nxt;
        timer_run_r   <= timer_run_nxt;
      end
    end
  end

  // held frame and pending ack number are read only after being written
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_handle_r <= held_handle_nxt;
      held_seq_r    <= held_seq_nxt;
      def_ack_seq_r <= def_ack_seq_nxt;
    end
  end

  // result queue: up to two writes, one read per cycle
  assign in_tready  = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign {out_tuser, out_tdata, out_tlast} = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (n_res != 2'd0 && wr_ptr_r == QPTR_W'(i)) q_r[i] <= r_ent[0];
        if (n_res == 2'd2 && wr_ptr_r + QPTR_W'(1) == QPTR_W'(i)) q_r[i] <= r_ent[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + QPTR_W'(n_res);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_r + (in_fire ? (QPTR_W+1)'(n_res) : '0) - (QPTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_stop_and_wait_arq.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq: self-checking bench for the stop-and-wait ARQ block
// Drives link events on the request stream, predicts every result with a
// behavioral copy of both link ends, and compares each result field by field.
// A directed table comes first, then timer runs and randomized phases under
// several resend_ticks settings with random idling and one long output hold.
// ----------------------------------------------------------------------------

module tb_stop_and_wait_arq;

  localparam int IN_W        = 32;
  localparam int OUT_W       = 40;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 40000;
  localparam int PHASE_REQS  = 65;
  localparam logic [sawarq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [sawarq_pkg::OP_W-1:0] op;
    logic [7:0]      seq;
    logic [15:0]     handle;
    logic            dfree;
    logic            afree;
  } link_req_t;

  typedef struct packed {
    logic [sawarq_pkg::KIND_W-1:0] kind;
    logic [7:0]        seq;
    logic [15:0]       handle;
    logic [sawarq_pkg::ATT_W-1:0]  att;
    logic              acc;
    logic              last;
  } link_res_t;

  typedef struct packed {
    link_req_t req;
    logic      typed;
    link_res_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [sawarq_pkg::CFG_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic [sawarq_pkg::OP_W-1:0]  in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [sawarq_pkg::KIND_W-1:0] out_tuser;
  logic             out_tlast;

  stop_and_wait_arq u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    // tdata, low to high: seq_in, frame_handle, data_path_free, ack_path_free
    .in_tdata    (in_tdata),
    // tuser: operation
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    // tdata, low to high: seq_out, handle_out, attempt, accepting
    .out_tdata   (out_tdata),
    // tuser: kind
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // link model state
  logic [sawarq_pkg::CFG_W-1:0] resend_cfg;
  logic [7:0]       tx_next;
  logic [7:0]       rx_expect;
  logic             outstanding;
  logic [15:0]      hold_handle;
  logic [7:0]       hold_seq;
  logic [sawarq_pkg::ATT_W-1:0] attempts;
  logic             tx_deferred;
  logic             ack_pending;
  logic [7:0]       pending_ack_seq;
  logic [15:0]      timer_cnt;
  logic             timer_on;

  link_res_t step_out [2];
  int        step_n;
  link_res_t pending_results [$];

  int errors;
  int idle_pct;
  int hold_reqs;
  int hold_done;
  dir_row_t dir_tab [$];
  link_res_t got, want;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic link_req_t mk_req(logic [sawarq_pkg::OP_W-1:0] op, logic [7:0] seq,
                                       logic [15:0] handle, logic dfree, logic afree);
    link_req_t r;
    r.op = op;
    r.seq = seq;
    r.handle = handle;
    r.dfree = dfree;
    r.afree = afree;
    return r;
  endfunction

  function automatic dir_row_t plain_row(link_req_t r);
    dir_row_t d;
    d = '0;
    d.req = r;
    return d;
  endfunction

  function automatic dir_row_t typed_row(link_req_t r, logic [sawarq_pkg::KIND_W-1:0] kind,
                                         logic [7:0] seq, logic [15:0] handle,
                                         logic [sawarq_pkg::ATT_W-1:0] att, logic acc);
    dir_row_t d;
    d.req = r;
    d.typed = 1'b1;
    d.want = '{kind: kind, seq: seq, handle: handle, att: att, acc: acc, last: 1'b1};
    return d;
  endfunction

  function automatic void put_result(logic [sawarq_pkg::KIND_W-1:0] kind, logic [7:0] seq,
                                     logic [15:0] handle, logic [sawarq_pkg::ATT_W-1:0] att);
    step_out[step_n] = '{kind: kind, seq: seq, handle: handle, att: att,
                         acc: 1'b0, last: 1'b0};
    step_n++;
  endfunction

  function automatic void send_held_frame();
    timer_cnt = resend_cfg;
    timer_on = 1'b1;
    tx_deferred = 1'b0;
    put_result(sawarq_pkg::KIND_DATA, hold_seq, hold_handle, attempts);
  endfunction

  // one link event; results land in step_out[0 .. step_n-1]
  function automatic void advance_link(link_req_t r);
    logic [7:0] prev;
    logic fresh;
    step_n = 0;
    case (r.op)
      sawarq_pkg::OP_SUBMIT: begin
        if (outstanding) begin
          put_result(sawarq_pkg::KIND_ERROR, '0, '0, '0);
        end else begin
          outstanding = 1'b1;
          hold_handle = r.handle;
          hold_seq = tx_next;
          attempts = 8'd1;
          tx_next = tx_next + 8'd1;
          if (r.dfree) send_held_frame();
          else tx_deferred = 1'b1;
        end
      end
      sawarq_pkg::OP_DATA_IN: begin
        prev = rx_expect - 8'd1;
        fresh = (r.seq == rx_expect);
        if (!fresh && r.seq != prev) begin
          put_result(sawarq_pkg::KIND_ERROR, '0, '0, '0);
        end else begin
          if (fresh) rx_expect = rx_expect + 8'd1;
          if (r.afree) begin
            ack_pending = 1'b0;
            put_result(sawarq_pkg::KIND_ACK, rx_expect, '0, '0);
          end else begin
            ack_pending = 1'b1;
            pending_ack_seq = rx_expect;
          end
          if (fresh) put_result(sawarq_pkg::KIND_UP, r.seq, r.handle, '0);
        end
      end
      sawarq_pkg::OP_ACK_IN: begin
        prev = tx_next - 8'd1;
        if (r.seq != tx_next && r.seq != prev) begin
          put_result(sawarq_pkg::KIND_ERROR, '0, '0, '0);
        end else if (r.seq == tx_next && outstanding) begin
          outstanding = 1'b0;
          tx_deferred = 1'b0;
          timer_on = 1'b0;
          timer_cnt = '0;
          put_result(sawarq_pkg::KIND_READY, '0, '0, '0);
        end
      end
      sawarq_pkg::OP_TICK: begin
        if (timer_on) begin
          if (timer_cnt > 16'd1) begin
            timer_cnt = timer_cnt - 16'd1;
          end else begin
            // timeout; a zero setting lands here on the first tick
            timer_cnt = '0;
            timer_on = 1'b0;
            if (outstanding) begin
              if (attempts < sawarq_pkg::ATT_MAX) attempts = attempts + 8'd1;
              if (r.dfree) send_held_frame();
              else tx_deferred = 1'b1;
            end
          end
        end
      end
      sawarq_pkg::OP_DATA_WAKE: begin
        if (tx_deferred && outstanding && r.dfree) send_held_frame();
        if (!outstanding && r.dfree) put_result(sawarq_pkg::KIND_READY, '0, '0, '0);
      end
      sawarq_pkg::OP_ACK_WAKE: begin
        if (ack_pending && r.afree) begin
          ack_pending = 1'b0;
          put_result(sawarq_pkg::KIND_ACK, pending_ack_seq, '0, '0);
        end
      end
      sawarq_pkg::OP_QUERY: put_result(sawarq_pkg::KIND_STATUS, '0, '0, attempts);
      default: ;
    endcase
    for (int i = 0; i < step_n; i++) begin
      step_out[i].acc = !outstanding && r.dfree;
      step_out[i].last = (i == step_n - 1);
    end
  endfunction

  // random event, steered toward in-sequence data and acks
  function automatic link_req_t pick_req();
    link_req_t r;
    int w;
    int p;
    w = $urandom_range(99);
    p = $urandom_range(99);
    r.seq = 8'($urandom);
    r.handle = 16'($urandom);
    r.dfree = ($urandom_range(99) < 75);
    r.afree = ($urandom_range(99) < 75);
    if (w < 15) r.op = sawarq_pkg::OP_SUBMIT;
    else if (w < 35) r.op = sawarq_pkg::OP_DATA_IN;
    else if (w < 55) r.op = sawarq_pkg::OP_ACK_IN;
    else if (w < 75) r.op = sawarq_pkg::OP_TICK;
    else if (w < 84) r.op = sawarq_pkg::OP_DATA_WAKE;
    else if (w < 93) r.op = sawarq_pkg::OP_ACK_WAKE;
    else if (w < 98) r.op = sawarq_pkg::OP_QUERY;
    else r.op = OP_UNUSED;
    if (r.op == sawarq_pkg::OP_DATA_IN) begin
      if (p < 70) r.seq = rx_expect;
      else if (p < 85) r.seq = rx_expect - 8'd1;
    end else if (r.op == sawarq_pkg::OP_ACK_IN) begin
      if (p < 60) r.seq = tx_next;
      else if (p < 80) r.seq = tx_next - 8'd1;
    end
    return r;
  endfunction

  task automatic offer(input link_req_t r, input logic typed, input link_res_t typed_want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'd0, r.afree, r.dfree, r.handle, r.seq};
    in_tuser = r.op;
    do @(posedge clk); while (!in_tready);
    advance_link(r);
    if (typed) begin
      pending_results.push_back(typed_want);
    end else begin
      for (int i = 0; i < step_n; i++) pending_results.push_back(step_out[i]);
    end
  endtask

  task automatic offer_req(input link_req_t r);
    offer(r, 1'b0, '0);
  endtask

  // block has drained: no request pending, every result seen
  task automatic wait_quiet();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_resend(input logic [sawarq_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    resend_cfg = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // make sure a frame is out with its timer running
  task automatic arm_frame();
    offer_req(mk_req(sawarq_pkg::OP_DATA_WAKE, 8'($urandom), 16'($urandom), 1'b1, 1'b1));
    if (!outstanding) begin
      offer_req(mk_req(sawarq_pkg::OP_SUBMIT, 8'($urandom), 16'($urandom), 1'b1, 1'b1));
    end
  endtask

  task automatic show_diff(input string name, input int unsigned exp_v,
                           input int unsigned act_v);
    errors++;
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, seq: out_tdata[7:0], handle: out_tdata[23:8],
              att: out_tdata[31:24], acc: out_tdata[32], last: out_tlast};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, actual 0x%0h",
                 $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) show_diff("kind", want.kind, got.kind);
        if (got.seq !== want.seq) show_diff("seq_out", want.seq, got.seq);
        if (got.handle !== want.handle) show_diff("handle_out", want.handle, got.handle);
        if (got.att !== want.att) show_diff("attempt", want.att, got.att);
        if (got.acc !== want.acc) show_diff("accepting", want.acc, got.acc);
        if (got.last !== want.last) show_diff("last", want.last, got.last);
      end
    end
  end

  // receiver side: random stalls, plus a long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done++;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [sawarq_pkg::CFG_W-1:0] phase_cfg [6];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    errors = 0;
    idle_pct = 27;
    hold_reqs = 0;
    hold_done = 0;
    resend_cfg = sawarq_pkg::RESEND_RST;
    tx_next = '0;
    rx_expect = '0;
    outstanding = 1'b0;
    hold_handle = '0;
    hold_seq = '0;
    attempts = '0;
    tx_deferred = 1'b0;
    ack_pending = 1'b0;
    pending_ack_seq = '0;
    timer_cnt = '0;
    timer_on = 1'b0;

    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_QUERY, 8'h00, 16'h0000, 1'b1, 1'b1),
                                sawarq_pkg::KIND_STATUS, 8'h00, 16'h0000, 8'd0, 1'b1));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_ACK_IN, 8'h00, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_ACK_IN, 8'h05, 16'h1234, 1'b0, 1'b1),
                                sawarq_pkg::KIND_ERROR, 8'h00, 16'h0000, 8'd0, 1'b0));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_DATA_IN, 8'hFF, 16'h0F0F, 1'b1, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_DATA_IN, 8'h00, 16'hFFFF, 1'b1, 1'b1)));
    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_DATA_IN, 8'h80, 16'h8000, 1'b1, 1'b1),
                                sawarq_pkg::KIND_ERROR, 8'h00, 16'h0000, 8'd0, 1'b1));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_DATA_IN, 8'h01, 16'h0000, 1'b1, 1'b0)));
    // second ack on a busy path replaces the first
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_DATA_IN, 8'h02, 16'h00FF, 1'b0, 1'b0)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_ACK_WAKE, 8'h00, 16'h0000, 1'b1, 1'b0)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_ACK_WAKE, 8'h00, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_SUBMIT, 8'h00, 16'hA5A5, 1'b1, 1'b1),
                                sawarq_pkg::KIND_DATA, 8'h00, 16'hA5A5, 8'd1, 1'b0));
    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_SUBMIT, 8'h00, 16'h1111, 1'b1, 1'b1),
                                sawarq_pkg::KIND_ERROR, 8'h00, 16'h0000, 8'd0, 1'b0));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_ACK_IN, 8'h00, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_ACK_IN, 8'h01, 16'h0000, 1'b1, 1'b1),
                                sawarq_pkg::KIND_READY, 8'h00, 16'h0000, 8'd0, 1'b1));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_SUBMIT, 8'h00, 16'h5A5A, 1'b0, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_DATA_WAKE, 8'h00, 16'h0000, 1'b0, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_DATA_WAKE, 8'h00, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_TICK, 8'h00, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_ACK_IN, 8'h02, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(typed_row(mk_req(sawarq_pkg::OP_DATA_WAKE, 8'h00, 16'h0000, 1'b1, 1'b1),
                                sawarq_pkg::KIND_READY, 8'h00, 16'h0000, 8'd0, 1'b1));
    dir_tab.push_back(plain_row(mk_req(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_SUBMIT, 8'h00, 16'h0000, 1'b1, 1'b1)));
    dir_tab.push_back(plain_row(mk_req(sawarq_pkg::OP_QUERY, 8'h00, 16'h0000, 1'b0, 1'b0)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    // clear the frame left out by the table
    offer_req(mk_req(sawarq_pkg::OP_ACK_IN, tx_next, 16'($urandom), 1'b1, 1'b1));
    wait_quiet();

    phase_cfg[0] = 16'd1;
    phase_cfg[1] = 16'd0;
    phase_cfg[2] = 16'hFFFF;
    phase_cfg[3] = 16'd3;
    phase_cfg[4] = 16'd2;
    phase_cfg[5] = 16'($urandom_range(12, 1));

    for (int ph = 0; ph < 6; ph++) begin
      write_resend(phase_cfg[ph]);
      idle_pct = (ph == 2) ? 0 : 27;
      if (ph == 3) hold_reqs++;
      if (ph == 0) begin
        // one tick per timeout: drive the attempt count into saturation
        arm_frame();
        for (int k = 0; k < 270; k++) begin
          if (k % 50 == 49) begin
            offer_req(mk_req(sawarq_pkg::OP_QUERY, 8'($urandom), 16'($urandom),
                             1'b1, 1'b1));
          end else begin
            offer_req(mk_req(sawarq_pkg::OP_TICK, 8'($urandom), 16'($urandom),
                             1'b1, 1'($urandom)));
          end
        end
        offer_req(mk_req(sawarq_pkg::OP_ACK_IN, tx_next, 16'($urandom), 1'b1, 1'b1));
      end
      for (int k = 0; k < PHASE_REQS; k++) offer_req(pick_req());
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: results still expected: expected 0, actual %0d left",
               $time, pending_results.size());
    end
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[stop_and_wait_arq.f]
src/sawarq_pkg.sv
src/stop_and_wait_arq.sv
tb/sv/tb_stop_and_wait_arq.sv
